FILE: sv/scc_pkg.sv
// shared types, constants and the object shape decoder of the copying collector
// no dependencies
`default_nettype none
package scc_pkg;

    localparam int SEMI_WORDS = 4096;
    localparam int WIDX_W     = $clog2(SEMI_WORDS);
    localparam int ADDR_W     = WIDX_W + 1;
    localparam int FILL_W     = WIDX_W + 1;
    localparam int SPAN_W     = WIDX_W + 2;

    localparam logic [31:0] SEMI_W32 = 32'(SEMI_WORDS);

    localparam logic [2:0] TAG_STRING = 3'd1;
    localparam logic [2:0] TAG_ARRAY  = 3'd3;
    localparam logic [2:0] TAG_SEXP   = 3'd5;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_RELOC   = 2'd1;
    localparam logic [1:0] REQ_COLLECT = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_TAG = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_R_CHK, S_R_HDR, S_R_CRD, S_R_CWR, S_R_FWD,
        S_C_TOP, S_C_HDR, S_C_FRD, S_C_FREL, S_C_FWR, S_C_UNS, S_C_UN1,
        S_C_UN2, S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              take;
        logic [1:0]        req_type;
        logic [WIDX_W-1:0] idx;
        logic [31:0]       value;
    } t_req;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [31:0] value;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic        known;
        logic        pre2;
        logic [29:0] body;
    } t_shape;

    function automatic t_shape obj_shape(input logic [31:0] hdr);
        t_shape s;
        s.known = 1'b1;
        s.pre2  = 1'b0;
        s.body  = {1'b0, hdr[31:3]};
        unique case (hdr[2:0])
            TAG_ARRAY: begin
            end
            TAG_SEXP: begin
                s.pre2 = 1'b1;
            end
            TAG_STRING: begin
                s.body = 30'(({1'b0, hdr[31:3]} + 30'd4) >> 2);
            end
            default: begin
                s.known = 1'b0;
            end
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: sv/scc_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/scc_engine.sv
// collector sequencer: word reads and writes, relocation, copy and scan over the semispace ram
// depends on scc_pkg and scc_ram
`default_nettype none
module scc_engine import scc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_base_a,
    input  wire logic [31:0] i_base_b,
    input  wire t_req        i_req,
    output t_rsp             o_rsp
);
    t_state r_state, n_state;
    logic              r_active, n_active;
    logic [FILL_W-1:0] r_fill, n_fill, r_scan, n_scan;
    logic [31:0]       r_v, n_v, r_res, n_res, r_chdr, n_chdr;
    logic [1:0]        r_st, n_st;
    logic [WIDX_W-1:0] r_w, n_w;
    logic              r_rpre2, n_rpre2, r_cpre2, n_cpre2, r_sub, n_sub;
    logic [FILL_W-1:0] r_total, n_total, r_i, n_i, r_cbody, n_cbody, r_j, n_j;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wd, mem_rd;

    logic [31:0]       base_act, base_pas, off, newp, fwd_off;
    logic [WIDX_W-1:0] w_c, src_i, dst_i, fld_i;
    logic [FILL_W-1:0] i_sw, fill_pre;
    t_shape            sh;
    logic [1:0]        pre_n, cpre_n;
    logic [31:0]       rsum_w, rsum_f, csum;
    logic              f_go;
    logic [31:0]       f_val;
    logic [1:0]        f_st;

    scc_ram #(.WIDTH(32), .DEPTH(2 * SEMI_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wd),
        .o_rdata(mem_rd)
    );

    // shared datapath terms
    always_comb begin
        base_act = r_active ? i_base_b : i_base_a;
        base_pas = r_active ? i_base_a : i_base_b;
        off      = r_v - base_act;
        w_c      = off[WIDX_W+1:2];
        sh       = obj_shape(mem_rd);
        pre_n    = sh.pre2 ? 2'd2 : 2'd1;
        cpre_n   = r_cpre2 ? 2'd2 : 2'd1;
        fwd_off  = mem_rd - base_pas;
        rsum_w   = 32'(r_w) + {2'b0, sh.body};
        rsum_f   = 32'(r_fill) + 32'(pre_n) + {2'b0, sh.body};
        csum     = 32'(r_scan) + 32'(pre_n) + {2'b0, sh.body};
        i_sw     = (r_rpre2 && r_i < FILL_W'(2)) ? {r_i[FILL_W-1:1], ~r_i[0]} : r_i;
        src_i    = r_w - WIDX_W'(r_rpre2 ? 2'd2 : 2'd1) + r_i[WIDX_W-1:0];
        dst_i    = r_fill[WIDX_W-1:0] + i_sw[WIDX_W-1:0];
        fld_i    = r_scan[WIDX_W-1:0] + WIDX_W'(cpre_n) + r_j[WIDX_W-1:0];
        fill_pre = r_fill + FILL_W'(r_rpre2 ? 2'd2 : 2'd1);
        newp     = base_pas + {{(32-FILL_W-2){1'b0}}, fill_pre, 2'b00};
    end

    // next state and datapath registers
    always_comb begin
        n_state = r_state;
        n_active = r_active; n_fill = r_fill; n_scan = r_scan;
        n_v = r_v; n_res = r_res; n_st = r_st; n_chdr = r_chdr;
        n_w = r_w; n_rpre2 = r_rpre2; n_cpre2 = r_cpre2; n_sub = r_sub;
        n_total = r_total; n_i = r_i; n_cbody = r_cbody; n_j = r_j;
        f_go = 1'b0; f_val = r_v; f_st = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res = 32'd0;
                    n_st  = ST_OK;
                    n_sub = 1'b0;
                    n_v   = i_req.value;
                    unique case (i_req.req_type)
                        REQ_WRITE:   n_state = S_DONE;
                        REQ_RELOC:   n_state = S_R_CHK;
                        REQ_COLLECT: n_state = S_C_TOP;
                        default:     n_state = S_RD_WAIT;
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_res   = mem_rd;
                n_state = S_DONE;
            end
            S_R_CHK: begin
                n_w = w_c;
                if (r_v[0] || off[31:SPAN_W] != '0) begin
                    f_go = 1'b1;
                end else if (w_c == '0) begin
                    f_go = 1'b1;
                    f_st = ST_OVF;
                end else begin
                    n_state = S_R_HDR;
                end
            end
            S_R_HDR: begin
                n_rpre2 = sh.pre2;
                n_total = FILL_W'(32'(pre_n) + {2'b0, sh.body});
                n_i     = '0;
                if (!mem_rd[0] && fwd_off[31:SPAN_W] == '0) begin
                    f_go  = 1'b1;
                    f_val = mem_rd;
                end else if (!sh.known) begin
                    f_go = 1'b1;
                    f_st = ST_TAG;
                end else if ((sh.pre2 && r_w == WIDX_W'(1)) || rsum_w > SEMI_W32
                             || rsum_f > SEMI_W32) begin
                    f_go = 1'b1;
                    f_st = ST_OVF;
                end else begin
                    n_state = S_R_CRD;
                end
            end
            S_R_CRD: begin
                n_state = (r_i == r_total) ? S_R_FWD : S_R_CWR;
            end
            S_R_CWR: begin
                n_i     = r_i + FILL_W'(1);
                n_state = S_R_CRD;
            end
            S_R_FWD: begin
                n_fill = r_fill + r_total;
                f_go   = 1'b1;
                f_val  = newp;
            end
            S_C_TOP: begin
                if (r_scan < r_fill) begin
                    n_state = S_C_HDR;
                end else begin
                    n_active = ~r_active;
                    n_res    = 32'(r_fill);
                    n_st     = ST_OK;
                    n_fill   = '0;
                    n_scan   = '0;
                    n_state  = S_DONE;
                end
            end
            S_C_HDR: begin
                n_chdr  = mem_rd;
                n_cpre2 = sh.pre2;
                n_cbody = sh.body[FILL_W-1:0];
                n_j     = '0;
                if (!sh.known) begin
                    n_res = 32'(r_fill); n_st = ST_TAG; n_state = S_DONE;
                end else if (csum > 32'(r_fill)) begin
                    n_res = 32'(r_fill); n_st = ST_OVF; n_state = S_DONE;
                end else if (mem_rd[2:0] == TAG_STRING) begin
                    n_state = S_C_UNS;
                end else begin
                    n_state = S_C_FRD;
                end
            end
            S_C_FRD: begin
                n_state = (r_j == r_cbody) ? S_C_UNS : S_C_FREL;
            end
            S_C_FREL: begin
                n_v     = mem_rd;
                n_sub   = 1'b1;
                n_state = S_R_CHK;
            end
            S_C_FWR: begin
                n_j     = r_j + FILL_W'(1);
                n_state = S_C_FRD;
            end
            S_C_UNS: begin
                if (r_cpre2) begin
                    n_state = S_C_UN1;
                end else begin
                    n_scan  = r_scan + FILL_W'(cpre_n) + r_cbody;
                    n_state = S_C_TOP;
                end
            end
            S_C_UN1: begin
                n_state = S_C_UN2;
            end
            S_C_UN2: begin
                n_scan  = r_scan + FILL_W'(cpre_n) + r_cbody;
                n_state = S_C_TOP;
            end
            S_DONE: begin
                if (i_req.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // end of one relocation, standalone or for a scanned field
        if (f_go) begin
            if (r_sub) begin
                if (f_st == ST_OK) begin
                    n_res   = f_val;
                    n_state = S_C_FWR;
                end else begin
                    n_res   = 32'(n_fill);
                    n_st    = f_st;
                    n_state = S_DONE;
                end
            end else begin
                n_res   = (f_st == ST_OK) ? f_val : r_v;
                n_st    = f_st;
                n_state = S_DONE;
            end
        end
    end

    // memory port and response
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = {r_active, r_w};
        mem_wd   = r_res;
        unique case (r_state)
            S_IDLE: begin
                mem_addr = {r_active, i_req.idx};
                mem_we   = i_req.valid && i_req.req_type == REQ_WRITE;
                mem_wd   = i_req.value;
            end
            S_R_CHK:  mem_addr = {r_active, w_c - WIDX_W'(1)};
            S_R_CRD:  mem_addr = {r_active, src_i};
            S_R_CWR: begin
                mem_we   = 1'b1;
                mem_addr = {~r_active, dst_i};
                mem_wd   = mem_rd;
            end
            S_R_FWD: begin
                mem_we   = 1'b1;
                mem_addr = {r_active, r_w - WIDX_W'(1)};
                mem_wd   = newp;
            end
            S_C_TOP:  mem_addr = {~r_active, r_scan[WIDX_W-1:0]};
            S_C_FRD:  mem_addr = {~r_active, fld_i};
            S_C_FWR: begin
                mem_we   = 1'b1;
                mem_addr = {~r_active, fld_i};
            end
            S_C_UNS:  mem_addr = {~r_active, r_scan[WIDX_W-1:0] + WIDX_W'(1)};
            S_C_UN1: begin
                mem_we   = 1'b1;
                mem_addr = {~r_active, r_scan[WIDX_W-1:0]};
                mem_wd   = mem_rd;
            end
            S_C_UN2: begin
                mem_we   = 1'b1;
                mem_addr = {~r_active, r_scan[WIDX_W-1:0] + WIDX_W'(1)};
                mem_wd   = r_chdr;
            end
            default: begin
            end
        endcase
        o_rsp.idle   = r_state == S_IDLE;
        o_rsp.done   = r_state == S_DONE;
        o_rsp.value  = r_res;
        o_rsp.status = r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_fill   <= '0;
            r_scan   <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_fill   <= n_fill;
            r_scan   <= n_scan;
            r_sub    <= n_sub;
        end
        r_v <= n_v; r_res <= n_res; r_st <= n_st; r_chdr <= n_chdr;
        r_w <= n_w; r_rpre2 <= n_rpre2; r_cpre2 <= n_cpre2;
        r_total <= n_total; r_i <= n_i; r_cbody <= n_cbody; r_j <= n_j;
    end
endmodule
`default_nettype wire

FILE: sv/semispace_copying_collector_top.sv
// top level of the semispace copying collector: handshakes, base registers, result beat
// depends on scc_pkg and scc_engine
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall | i_req_type, i_word_index, i_word_value
//  out     | output    | o_out_valid / i_out_stall | o_result_value, o_status
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// one beat is worked at a time through a single-port ram with registered read
// relocation checks the pointer and header, copies each word, writes a forward pointer
// collect reads each header, relocates array and sexp fields, reorders sexp words
// reset is synchronous; half a is active and the copy and scan marks are zero
// o_in_stall stays high from acceptance until the result beat is loaded
// a stalled result holds in the output register while the next beat is taken
`default_nettype none
module semispace_copying_collector_top import scc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [WIDX_W-1:0] i_word_index,
    input  wire logic [31:0]       i_word_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [31:0]            o_result_value,
    output logic [1:0]             o_status
);
    logic [31:0] r_base_a, r_base_b;
    logic        r_ovalid;
    logic [31:0] r_oval;
    logic [1:0]  r_ost;
    t_req        req;
    t_rsp        rsp;
    logic        take;

    // output register free, or being emptied this cycle
    assign take = !r_ovalid || !i_out_stall;

    assign o_in_stall = !rsp.idle;

    always_comb begin
        req.valid    = i_in_valid && rsp.idle;
        req.take     = take;
        req.req_type = i_req_type;
        req.idx      = i_word_index;
        req.value    = i_word_value;
    end

    scc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base_a(r_base_a),
        .i_base_b(r_base_b),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_a <= 32'd4096;
            r_base_b <= 32'd20480;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index) begin
                    r_base_b <= i_cfg_data;
                end else begin
                    r_base_a <= i_cfg_data;
                end
            end
            if (rsp.done && take) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (rsp.done && take) begin
            r_oval <= rsp.value;
            r_ost  <= rsp.status;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_value = r_oval;
    assign o_status       = r_ost;
endmodule
`default_nettype wire

FILE: bench/semispace_copying_collector_top_tb.sv
// self-checking bench of the semispace copying collector: heap building, root moves, collects
// depends on scc_pkg and semispace_copying_collector_top
`timescale 1ns / 100ps
module semispace_copying_collector_top_tb;
    import scc_pkg::*;

    localparam int        HEAP_WORDS = 2 * SEMI_WORDS;
    localparam bit        CFG_HALF_A = 1'b0;
    localparam bit        CFG_HALF_B = 1'b1;
    localparam bit [31:0] HDR_EMPTY  = {29'd0, TAG_ARRAY};

    // ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [31:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_req_type = REQ_READ;
    logic [WIDX_W-1:0] i_word_index = '0;
    logic [31:0]       i_word_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [31:0]       o_result_value;
    logic [1:0]        o_status;

    semispace_copying_collector_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // collector shadow: both halves, written marks, bases and marks
    // ---------------------------------------------------------------
    bit [31:0]   heap [0:HEAP_WORDS-1];
    bit [31:0]   heap_saved [0:HEAP_WORDS-1];
    bit          written [0:HEAP_WORDS-1];
    bit          written_saved [0:HEAP_WORDS-1];
    bit [31:0]   base_a = 32'd4096;
    bit [31:0]   base_b = 32'd20480;
    bit          side = 1'b0;
    int unsigned fill = 0;
    int unsigned scan = 0;
    bit          side_saved;
    int unsigned fill_saved, scan_saved;
    int          hole;       // first never-written word touched, -1 if none
    int          culprit;    // active header whose move failed, -1 if none

    typedef struct {
        bit [31:0] value;
        bit [1:0]  status;
    } t_result;

    t_result     result_q [$];
    int          errors = 0;
    int          beats_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    // stimulus bookkeeping
    bit [31:0]   roots [$];
    int unsigned alloc = 0;

    function automatic bit [31:0] half_base(bit h);
        return h ? base_b : base_a;
    endfunction

    function automatic int active_at();
        return side ? SEMI_WORDS : 0;
    endfunction

    function automatic bit [31:0] peek(int a);
        if (!written[a] && hole < 0)
            hole = a;
        return heap[a];
    endfunction

    function automatic void poke(int a, bit [31:0] d);
        heap[a] = d;
        written[a] = 1'b1;
    endfunction

    // words before and from the pointer; 0 for an unknown tag
    function automatic bit shape_of(bit [31:0] hdr, output longint pre, output longint body);
        longint len;
        len = longint'(hdr[31:3]);
        pre = 1;
        body = len;
        case (hdr[2:0])
            TAG_ARRAY:  return 1'b1;
            TAG_SEXP: begin
                pre = 2;
                return 1'b1;
            end
            TAG_STRING: begin
                body = (len + 4) >> 2;
                return 1'b1;
            end
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit [1:0] move_root(bit [31:0] v, output bit [31:0] res);
        int        act, pas;
        longint    w, pre, body;
        bit [31:0] hdr, off, gap;
        act = active_at();
        pas = SEMI_WORDS - act;
        res = v;
        if (v[0])
            return ST_OK;
        off = v - half_base(side);
        if (off >= 32'(4 * SEMI_WORDS))
            return ST_OK;
        w = longint'(off >> 2);
        if (w == 0)
            return ST_OVF;
        hdr = peek(act + int'(w) - 1);
        gap = hdr - half_base(!side);
        if (!hdr[0] && gap < 32'(4 * SEMI_WORDS)) begin
            res = hdr;
            return ST_OK;
        end
        culprit = act + int'(w) - 1;
        if (!shape_of(hdr, pre, body))
            return ST_TAG;
        if (w < pre || w + body > SEMI_WORDS || longint'(fill) + pre + body > SEMI_WORDS)
            return ST_OVF;
        culprit = -1;
        for (longint i = 0; i < pre + body; i++)
            poke(pas + int'(fill) + int'(i), peek(act + int'(w - pre + i)));
        if (pre == 2) begin
            poke(pas + int'(fill), hdr);
            poke(pas + int'(fill) + 1, peek(act + int'(w) - 2));
        end
        res = half_base(!side) + 32'(4 * (longint'(fill) + pre));
        poke(act + int'(w) - 1, res);
        fill += int'(pre + body);
        return ST_OK;
    endfunction

    // result is the copy mark as it stands when the collect ends or stops
    function automatic bit [1:0] collect_half(output bit [31:0] res);
        int        pas, at;
        longint    pre, body;
        bit [31:0] hdr, nv;
        bit [1:0]  st;
        pas = SEMI_WORDS - active_at();
        res = 32'(fill);
        while (scan < fill) begin
            res = 32'(fill);
            hdr = peek(pas + int'(scan));
            if (!shape_of(hdr, pre, body))
                return ST_TAG;
            if (longint'(scan) + pre + body > fill)
                return ST_OVF;
            if (hdr[2:0] != TAG_STRING) begin
                for (longint i = 0; i < body; i++) begin
                    at = pas + int'(scan) + int'(pre + i);
                    st = move_root(peek(at), nv);
                    if (st != ST_OK) begin
                        res = 32'(fill);
                        return st;
                    end
                    poke(at, nv);
                end
            end
            if (pre == 2) begin
                at = pas + int'(scan);
                poke(at, peek(at + 1));
                poke(at + 1, hdr);
            end
            scan += int'(pre + body);
        end
        res = 32'(fill);
        side = !side;
        fill = 0;
        scan = 0;
        return ST_OK;
    endfunction

    function automatic bit [1:0] serve_request(bit [1:0] req, int idx, bit [31:0] val,
                                               output bit [31:0] res);
        res = '0;
        culprit = -1;
        case (req)
            REQ_WRITE:   poke(active_at() + idx, val);
            REQ_RELOC:   return move_root(val, res);
            REQ_COLLECT: return collect_half(res);
            default:     res = peek(active_at() + idx);
        endcase
        return ST_OK;
    endfunction

    // ---------------------------------------------------------------
    // result side: random stall, long hold-off, and the comparison
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: value %h status %0d",
                           o_result_value, o_status);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (o_result_value !== want.value) begin
                        $error("result_value: expected %h, actual %h", want.value,
                               o_result_value);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // valid is left high after a beat so the next one can follow at once;
    // anything that lets time pass between beats drops it here first
    task automatic quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(bit [1:0] req, int idx, bit [31:0] val, bit [31:0] res,
                             bit [1:0] st);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_word_index <= WIDX_W'(idx);
        i_word_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        r.value = res;
        r.status = st;
        result_q.push_back(r);
        beats_sent++;
    endtask

    // writes never read, so they need no trial run
    task automatic put_word(int idx, bit [31:0] val);
        bit [31:0] res;
        bit [1:0]  st;
        st = serve_request(REQ_WRITE, idx, val, res);
        send_beat(REQ_WRITE, idx, val, res, st);
    endtask

    // trial-runs the request; a never-written active word that it would touch
    // is written first, so the block never sees an undefined read
    task automatic issue(bit [1:0] req, int idx, bit [31:0] val, output bit [31:0] res,
                         output bit [1:0] st);
        int act;
        forever begin
            heap_saved = heap;
            written_saved = written;
            side_saved = side;
            fill_saved = fill;
            scan_saved = scan;
            hole = -1;
            st = serve_request(req, idx, val, res);
            if (hole < 0)
                break;
            heap = heap_saved;
            written = written_saved;
            side = side_saved;
            fill = fill_saved;
            scan = scan_saved;
            act = active_at();
            if (hole < act || hole >= act + SEMI_WORDS) begin
                $error("stimulus would read an unwritten copied word %0d", hole);
                errors++;
                break;
            end
            put_word(hole - act, ($urandom & 32'h0000_00F8) | HDR_EMPTY);
        end
        send_beat(req, idx, val, res, st);
    endtask

    task automatic drain();
        quiet();
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_bases(bit [31:0] a, bit [31:0] b);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HALF_A;
        i_cfg_data  <= a;
        @(posedge i_clk);
        i_cfg_index <= CFG_HALF_B;
        i_cfg_data  <= b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        base_a = a;
        base_b = b;
        roots.delete();
    endtask

    function automatic bit [31:0] word_ptr(int w);
        return half_base(side) + 32'(4 * w);
    endfunction

    // lays out one object at the allocation mark; array and sexp fields point at live roots
    // or hold odd non-pointers, with an occasional even stray; string words are random
    task automatic make_object(bit [2:0] tag, int len, output bit [31:0] ptr,
                               output int hdr_at);
        int pre, body, w;
        bit [31:0] f;
        pre = (tag == TAG_SEXP) ? 2 : 1;
        body = (tag == TAG_STRING) ? (len + 4) / 4 : len;
        ptr = 32'h1;
        hdr_at = -1;
        if (alloc + pre + body > SEMI_WORDS)
            return;
        if (pre == 2)
            put_word(alloc, $urandom);
        hdr_at = alloc + pre - 1;
        put_word(hdr_at, {29'(len), tag});
        w = alloc + pre;
        for (int i = 0; i < body; i++) begin
            if (tag == TAG_STRING)
                f = $urandom;
            else if (roots.size() != 0 && $urandom_range(99) < 50)
                f = roots[$urandom_range(roots.size() - 1)];
            else if ($urandom_range(99) < 5)
                f = $urandom & 32'hFFFF_FFFE;
            else
                f = $urandom | 32'h1;
            put_word(w + i, f);
        end
        ptr = word_ptr(w);
        alloc = w + body;
    endtask

    // collect, patching a bad active header and retrying when one is found
    task automatic collect_and_swap(output bit [1:0] st, output bit [31:0] used);
        int act;
        for (int tries = 0; tries < 8; tries++) begin
            act = active_at();
            issue(REQ_COLLECT, 0, $urandom, used, st);
            if (st == ST_OK || culprit < act || culprit >= act + SEMI_WORDS)
                break;
            put_word(culprit - act, HDR_EMPTY);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        bit [31:0] res, str_p, arr_p, sx_p, used;
        bit [1:0]  st;
        int        h_at, y_at;
        // word range extremes
        put_word(0, 32'hFFFF_FFFF);
        issue(REQ_READ, 0, 32'h0, res, st);
        put_word(SEMI_WORDS - 1, 32'h0);
        issue(REQ_READ, SEMI_WORDS - 1, 32'hFFFF_FFFF, res, st);
        alloc = 1;
        // a small graph: sexp -> array -> string
        make_object(TAG_STRING, 5, str_p, h_at);
        roots = '{str_p};
        make_object(TAG_ARRAY, 3, arr_p, h_at);
        roots = '{arr_p};
        make_object(TAG_SEXP, 2, sx_p, h_at);
        roots.delete();
        issue(REQ_RELOC, 0, sx_p, res, st);
        roots.push_back(res);
        // second move follows the forward pointer
        issue(REQ_RELOC, 0, sx_p, res, st);
        issue(REQ_RELOC, 0, 32'h0000_1235, res, st);            // odd, not a pointer
        issue(REQ_RELOC, 0, base_a + 32'(4 * SEMI_WORDS), res, st); // past the half
        issue(REQ_RELOC, 0, base_a, res, st);                   // header before word 0
        // unknown tags: tag 7 and an even header that is no forward pointer
        put_word(alloc, 32'h0000_0017);
        issue(REQ_RELOC, 0, word_ptr(alloc + 1), res, st);
        put_word(alloc + 1, 32'h0000_0010);
        issue(REQ_RELOC, 0, word_ptr(alloc + 2), res, st);
        // sexp whose constructor would fall before word 0
        put_word(0, {29'd0, TAG_SEXP});
        issue(REQ_RELOC, 0, word_ptr(1), res, st);
        // array running past the end of the half
        put_word(SEMI_WORDS - 6, {29'd20, TAG_ARRAY});
        issue(REQ_RELOC, 0, word_ptr(SEMI_WORDS - 5), res, st);
        issue(REQ_RELOC, 0, arr_p, res, st);
        issue(REQ_RELOC, 0, str_p, res, st);
        collect_and_swap(st, used);
        alloc = used;
        roots.delete();
        // collect stopping on a bad field target, then resuming
        make_object(TAG_ARRAY, 0, res, y_at);
        roots = '{res};
        make_object(TAG_ARRAY, 1, arr_p, h_at);
        // its only field points at the object whose header gets broken
        put_word(h_at + 1, res);
        put_word(y_at, 32'h0000_0007);
        issue(REQ_RELOC, 0, arr_p, res, st);
        issue(REQ_COLLECT, 0, 32'h0, used, st);
        put_word(y_at, HDR_EMPTY);
        collect_and_swap(st, used);
        alloc = used;
        roots.delete();
        issue(REQ_READ, 0, 32'h0, res, st);
    endtask

    task automatic test_random_heap(int beats, int snd_pct, int rcv_pct);
        bit [31:0] res, ptr, used;
        bit [1:0]  st;
        bit [2:0]  tag;
        bit [31:0] moved [$];
        int        stop, h_at, len;
        send_idle_pct = snd_pct;
        recv_stall_pct = rcv_pct;
        stop = beats_sent + beats;
        while (beats_sent < stop) begin
            // grow the heap
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(2))
                    0:       tag = TAG_ARRAY;
                    1:       tag = TAG_SEXP;
                    default: tag = TAG_STRING;
                endcase
                len = ($urandom_range(99) < 90) ? $urandom_range(0, 5) : $urandom_range(6, 40);
                make_object(tag, len, ptr, h_at);
                if (h_at >= 0 && roots.size() < 30)
                    roots.push_back(ptr);
            end
            // move a share of the roots, with noise mixed in
            moved.delete();
            foreach (roots[i]) begin
                if ($urandom_range(99) < 70) begin
                    issue(REQ_RELOC, 0, roots[i], res, st);
                    if (st == ST_OK)
                        moved.push_back(res);
                end
                case ($urandom_range(19))
                    0: issue(REQ_RELOC, 0, $urandom, res, st);
                    1: issue(REQ_READ, $urandom_range(SEMI_WORDS - 1), $urandom, res, st);
                    2: if (alloc < SEMI_WORDS)
                        put_word($urandom_range(SEMI_WORDS - 1, alloc), $urandom | 32'h1);
                    default: ;
                endcase
            end
            collect_and_swap(st, used);
            if (st == ST_OK) begin
                roots = moved;
                alloc = used;
            end else begin
                roots.delete();
            end
        end
    endtask

    task automatic test_backpressure();
        bit [31:0] res;
        bit [1:0]  st;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            issue(REQ_READ, $urandom_range(alloc > 0 ? alloc - 1 : 0), $urandom, res, st);
        // pause until the block has answered everything
        drain();
        issue(REQ_RELOC, 0, 32'h3, res, st);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_heap(350, 0, 0);
        write_bases(32'h0, 32'hFFFF_FFFC);
        test_random_heap(350, 86, 0);
        write_bases(32'hFFFF_FFFC, 32'h0);
        test_random_heap(350, 0, 86);
        write_bases($urandom_range(32'hFFFF_FFFC, 0), $urandom_range(32'hFFFF_FFFC, 0));
        test_backpressure();
        write_bases(32'd4096, 32'd20480);
        test_random_heap(350, 35, 35);
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0)
            $display("semispace_copying_collector_top test passed");
        else
            $display("semispace_copying_collector_top test failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("semispace_copying_collector_top test failed");
        $finish;
    end

endmodule
